### design/tme_pkg.sv
// package for the text to morse encoder: symbol codes, job descriptor,
// character folding functions and the morse code tables. no dependencies.
`default_nettype none

package tme_pkg;

  typedef enum logic [2:0] {
    SYM_DOT     = 3'd0,
    SYM_DASH    = 3'd1,
    SYM_GAP     = 3'd2,
    SYM_SLASH   = 3'd3,
    SYM_OK      = 3'd4,
    SYM_INVALID = 3'd5,
    SYM_EMPTY   = 3'd6
  } sym_e;

  // utf-8 lead byte tracking
  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_C3   = 2'd1,
    LEAD_C4   = 2'd2,
    LEAD_C5   = 2'd3
  } lead_e;

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] LeadC3  = 8'hC3;
  localparam logic [7:0] LeadC4  = 8'hC4;
  localparam logic [7:0] LeadC5  = 8'hC5;

  localparam int unsigned NumCodes = 36;
  localparam int unsigned IdxW     = $clog2(NumCodes);

  // one unit of work for the back end, emitted in field order:
  // slash, len code symbols (msb first), gap, end status
  typedef struct packed {
    logic        slash;
    logic [2:0]  len;
    logic [4:0]  bits;
    logic        gap;
    logic        has_end;
    sym_e        end_sym;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // index 0..25 for a..z, 26..35 for digits; pattern read from bit len-1, 1 = dash
  localparam logic [2:0] CODE_LEN [NumCodes] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [4:0] CODE_BITS [NumCodes] = '{
    5'h01, 5'h08, 5'h0A, 5'h04, 5'h00, 5'h02, 5'h06, 5'h00, 5'h00, 5'h07, 5'h05,
    5'h04, 5'h03, 5'h02, 5'h07, 5'h06, 5'h0D, 5'h02, 5'h00, 5'h01, 5'h01, 5'h01,
    5'h03, 5'h09, 5'h0B, 5'h0C, 5'h1F, 5'h0F, 5'h07, 5'h03, 5'h01, 5'h00, 5'h10,
    5'h18, 5'h1C, 5'h1E
  };

  // returns {ok, table index}
  function automatic logic [IdxW:0] fold_single(input logic [7:0] b);
    logic [7:0] ch;
    logic [7:0] t;
    ch = b;
    t  = '0;
    case (b)
      8'hC7, 8'hE7: ch = 8'h43; // c cedilla
      8'hD0, 8'hF0: ch = 8'h47; // soft g
      8'hDD, 8'hFD: ch = 8'h49; // dotted and dotless i
      8'hD6, 8'hF6: ch = 8'h4F; // o umlaut
      8'hDE, 8'hFE: ch = 8'h53; // s cedilla
      8'hDC, 8'hFC: ch = 8'h55; // u umlaut
      default:      ch = b;
    endcase
    if (ch >= 8'h61 && ch <= 8'h7A) ch = ch - 8'h20;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      t = ch - 8'h41;
      return {1'b1, t[IdxW-1:0]};
    end
    if (ch >= 8'h30 && ch <= 8'h39) begin
      t = ch - 8'h30 + 8'd26;
      return {1'b1, t[IdxW-1:0]};
    end
    return '0;
  endfunction

  function automatic logic [IdxW:0] fold_pair(input lead_e lead, input logic [7:0] b);
    logic [7:0] ch;
    logic [7:0] t;
    ch = '0;
    t  = '0;
    case (lead)
      LEAD_C3: begin
        if (b == 8'h87 || b == 8'hA7) ch = 8'h43;
        else if (b == 8'h96 || b == 8'hB6) ch = 8'h4F;
        else if (b == 8'h9C || b == 8'hBC) ch = 8'h55;
      end
      LEAD_C4: begin
        if (b == 8'h9E || b == 8'h9F) ch = 8'h47;
        else if (b == 8'hB0 || b == 8'hB1) ch = 8'h49;
      end
      LEAD_C5: begin
        if (b == 8'h9E || b == 8'h9F) ch = 8'h53;
      end
      default: ch = '0;
    endcase
    if (ch == 8'h00) return '0;
    t = ch - 8'h41;
    return {1'b1, t[IdxW-1:0]};
  endfunction

endpackage

`default_nettype wire

### design/tme_front.sv
// front end: takes text bytes, folds and classifies them, tracks the text
// state and pushes one job per byte that gives any output. uses tme_pkg.
`default_nettype none

module tme_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    text_byte_i,
  input  wire logic          end_of_text_i,
  output logic               push_o,
  output tme_pkg::job_t      job_o
);
  import tme_pkg::*;

  lead_e lead_q, lead_d;
  logic  failed_q, failed_d;
  logic  any_q, any_d;

  logic [IdxW:0] fold;
  logic          letter;
  logic          space;
  logic          invalid;
  logic          conv;
  logic [7:0]    lead_diff;

  always_comb begin
    lead_d    = lead_q;
    failed_d  = failed_q;
    any_d     = any_q;
    push_o    = 1'b0;
    job_o     = '0;
    job_o.end_sym = SYM_EMPTY;
    fold      = '0;
    letter    = 1'b0;
    space     = 1'b0;
    invalid   = 1'b0;
    conv      = any_q;
    lead_diff = text_byte_i - 8'hC2;

    if (accept_i) begin
      if (failed_q) begin
        // rest of a failed text is dropped
        if (end_of_text_i) begin
          lead_d   = LEAD_NONE;
          failed_d = 1'b0;
          any_d    = 1'b0;
        end
      end else begin
        if (lead_q != LEAD_NONE) begin
          fold    = fold_pair(lead_q, text_byte_i);
          lead_d  = LEAD_NONE;
          letter  = fold[IdxW];
          invalid = !fold[IdxW];
        end else if (text_byte_i == ChLf || text_byte_i == ChCr || text_byte_i == ChTab) begin
          letter = 1'b0;
        end else if (text_byte_i == ChSpace) begin
          space = 1'b1;
        end else if (text_byte_i == LeadC3 || text_byte_i == LeadC4 ||
                     text_byte_i == LeadC5) begin
          lead_d  = lead_e'(lead_diff[1:0]);
          invalid = end_of_text_i;
        end else begin
          fold    = fold_single(text_byte_i);
          letter  = fold[IdxW];
          invalid = !fold[IdxW];
        end

        conv = any_q | letter;
        if (invalid) begin
          push_o        = 1'b1;
          job_o.has_end = 1'b1;
          job_o.end_sym = SYM_INVALID;
          lead_d        = LEAD_NONE;
          failed_d      = !end_of_text_i;
          if (end_of_text_i) any_d = 1'b0;
        end else begin
          push_o        = space | letter | end_of_text_i;
          job_o.slash   = space;
          job_o.gap     = space | letter;
          job_o.len     = letter ? CODE_LEN[fold[IdxW-1:0]] : 3'd0;
          job_o.bits    = letter ? CODE_BITS[fold[IdxW-1:0]] : 5'd0;
          job_o.has_end = end_of_text_i;
          job_o.end_sym = conv ? SYM_OK : SYM_EMPTY;
          any_d         = conv;
          if (end_of_text_i) begin
            lead_d   = LEAD_NONE;
            failed_d = 1'b0;
            any_d    = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= LEAD_NONE;
      failed_q <= 1'b0;
      any_q    <= 1'b0;
    end else begin
      lead_q   <= lead_d;
      failed_q <= failed_d;
      any_q    <= any_d;
    end
  end

endmodule

`default_nettype wire

### design/tme_queue.sv
// two-entry job queue between front and back end. uses tme_pkg.
`default_nettype none

module tme_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tme_pkg::job_t push_job_i,
  input  wire logic          pop_i,
  output tme_pkg::job_t      head_o,
  output tme_pkg::q_stat_t   stat_o
);
  import tme_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### design/tme_back.sv
// back end: walks the current job one symbol per cycle into the output register while
// that register is free, loading the next job from the queue without a bubble. uses tme_pkg.
`default_nettype none

module tme_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tme_pkg::job_t    head_i,
  input  wire tme_pkg::q_stat_t q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  output tme_pkg::sym_e         out_sym_o,
  output logic                  out_last_o,
  input  wire logic             out_ready_i
);
  import tme_pkg::*;

  job_t       cur_q, cur_d, nxt;
  logic       cur_vld_q, cur_vld_d;
  logic [2:0] cnt_m1;
  sym_e       sym;
  logic       done;
  logic       step;
  logic       out_free;

  logic       oval_q;
  sym_e       osym_q;
  logic       olast_q;

  assign out_free    = !oval_q || out_ready_i;
  assign step        = cur_vld_q && out_free;
  assign out_valid_o = oval_q;
  assign out_sym_o   = osym_q;
  assign out_last_o  = olast_q;

  always_comb begin
    nxt    = cur_q;
    cnt_m1 = cur_q.len - 3'd1;
    if (cur_q.slash) begin
      sym       = SYM_SLASH;
      nxt.slash = 1'b0;
    end else if (cur_q.len != 3'd0) begin
      sym     = cur_q.bits[cnt_m1] ? SYM_DASH : SYM_DOT;
      nxt.len = cnt_m1;
    end else if (cur_q.gap) begin
      sym     = SYM_GAP;
      nxt.gap = 1'b0;
    end else begin
      sym         = cur_q.end_sym;
      nxt.has_end = 1'b0;
    end
    done = !(nxt.slash || (nxt.len != 3'd0) || nxt.gap || nxt.has_end);
  end

  always_comb begin
    pop_o     = !q_stat_i.empty && (!cur_vld_q || (step && done));
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    if (pop_o) begin
      cur_d     = head_i;
      cur_vld_d = 1'b1;
    end else if (step) begin
      cur_d     = nxt;
      cur_vld_d = !done;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (step) begin
      osym_q  <= sym;
      olast_q <= done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      oval_q    <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      if (step) oval_q <= 1'b1;
      else if (out_ready_i) oval_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### design/text_to_morse_encoder.sv
// top level of the text to morse encoder: front end, job queue, back end.
// depends on tme_pkg, tme_front, tme_queue and tme_back.
//
// Text goes in one byte per beat (tlast on the final byte) and Morse symbols
// come out one per beat, tlast marking the last symbol caused by each byte.
// A byte is taken whenever the two-entry job queue has room; it then gives
// 0 to 7 output beats (a slash or up to five dots or dashes, a gap, and an
// end status), and the back end sends one symbol per cycle while the output
// side accepts, so the sustained rate is set by the output side.
// After an invalid byte the remainder of that text is swallowed up to and
// including its final byte.
`default_nettype none

module text_to_morse_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] text_byte
  input  wire logic       s_axis_tlast,  // end_of_text
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [2:0] symbol, [7:3] zero
  output logic            m_axis_tlast   // run_last
);
  import tme_pkg::*;

  logic    accept;
  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head;
  q_stat_t q_stat;
  sym_e    out_sym;

  assign s_axis_tready = !q_stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {5'd0, out_sym};

  tme_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (s_axis_tdata),
    .end_of_text_i (s_axis_tlast),
    .push_o        (push),
    .job_o         (push_job)
  );

  tme_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  tme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_sym_o   (out_sym),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

  // an end status always closes the run of its byte
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_sym == SYM_OK || out_sym == SYM_INVALID || out_sym == SYM_EMPTY)
    |-> m_axis_tlast)
    else $error("end status beat without tlast");

  // a slash is always followed by its gap
  a_slash_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_sym == SYM_SLASH) |-> !m_axis_tlast)
    else $error("slash beat marked last");

  // at most one pop a cycle, so a full queue cannot drain at once
  a_queue_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |=> !q_stat.empty)
    else $error("queue went from full to empty in one cycle");

endmodule

`default_nettype wire
